// ===== sv/alpzt_pkg.sv =====
// ----------------------------------------------------------------------------
// alpzt_pkg
// Shared types, codes and character constants for the alert line parser
// and zone table.
// ----------------------------------------------------------------------------
package alpzt_pkg;

  // Default build values
  localparam int ZONES_DEF    = 25;
  localparam int LINE_MAX_DEF = 64;

  // Result queue depth; an item is taken only when two slots are free
  localparam int FIFO_DEPTH = 4;

  // Zone index field width (zones 1..32 map to index 0..31)
  localparam int ZIDX_W = 5;

  // Characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_S     = 8'h73;

  localparam logic [5:0] ACC_SAT = 6'd63;

  // Input operation
  localparam logic OP_BYTE      = 1'b0;
  localparam logic OP_RECONNECT = 1'b1;

  typedef enum logic [3:0] {
    ST_PING      = 4'd0,
    ST_UNCHANGED = 4'd1,
    ST_CHANGED   = 4'd2,
    ST_SHORT     = 4'd3,
    ST_BAD_DELIM = 4'd4,
    ST_BAD_TYPE  = 4'd5,
    ST_NO_EQUALS = 4'd6,
    ST_BAD_ZONE  = 4'd7,
    ST_BAD_STATE = 4'd8,
    ST_OVERFLOW  = 4'd9,
    ST_CLEARED   = 4'd10
  } status_t;

  typedef enum logic [1:0] {
    ZS_UNKNOWN = 2'd0,
    ZS_SAFE    = 2'd1,
    ZS_UNSAFE  = 2'd2
  } zstate_t;

  typedef enum logic [1:0] {
    PH_SKIP  = 2'd0,
    PH_SIGN  = 2'd1,
    PH_DIGIT = 2'd2,
    PH_DONE  = 2'd3
  } phase_t;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
    logic       chunk_start;
  } in_item_t;

  // Partial line fields, all zero on restart
  typedef struct packed {
    logic [7:0] type_c;
    logic [7:0] delim_c;
    logic [5:0] acc;
    phase_t     phase;
    logic       seen_eq;
    logic [7:0] state_c;
  } line_t;

  localparam line_t LINE_CLR = '0;

  // One result without the packed zone states
  typedef struct packed {
    status_t    status;
    logic [4:0] zone;
    zstate_t    old_s;
    zstate_t    new_s;
    logic       notify;
    logic       last;
  } res_t;

  // Zone table update request
  typedef struct packed {
    logic              clear;
    logic              we;
    logic [ZIDX_W-1:0] idx;
    zstate_t           val;
  } zt_wr_t;

endpackage

// ===== sv/alpzt_zone_table.sv =====
// ----------------------------------------------------------------------------
// alpzt_zone_table
// Per-zone 2-bit state registers with one read port, one write port, bulk
// clear, and the packed next-state view for results.
// ----------------------------------------------------------------------------
module alpzt_zone_table #(
  parameter int ZONES = alpzt_pkg::ZONES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  alpzt_pkg::zt_wr_t         wr,
  input  logic [alpzt_pkg::ZIDX_W-1:0] rd_idx,
  output alpzt_pkg::zstate_t        rd_state,
  output logic [2*ZONES-1:0]        states_nxt
);
  import alpzt_pkg::*;

  localparam int ZIW = (ZONES > 1) ? $clog2(ZONES) : 1;

  logic [1:0] zone_r   [ZONES];
  logic [1:0] zone_nxt [ZONES];

  logic [ZIW-1:0] widx;
  logic [ZIW-1:0] ridx;

  assign widx = wr.idx[ZIW-1:0];
  assign ridx = rd_idx[ZIW-1:0];

  assign rd_state = zstate_t'(zone_r[ridx]);

  always_comb begin
    for (int i = 0; i < ZONES; i++) begin
      zone_nxt[i] = zone_r[i];
    end
    if (wr.clear) begin
      for (int i = 0; i < ZONES; i++) begin
        zone_nxt[i] = ZS_UNKNOWN;
      end
    end else if (wr.we) begin
      zone_nxt[widx] = wr.val;
    end
    for (int i = 0; i < ZONES; i++) begin
      states_nxt[2*i +: 2] = zone_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ZONES; i++) begin
        zone_r[i] <= ZS_UNKNOWN;
      end
    end else begin
      for (int i = 0; i < ZONES; i++) begin
        zone_r[i] <= zone_nxt[i];
      end
    end
  end

endmodule

// ===== sv/alpzt_line_parser.sv =====
// ----------------------------------------------------------------------------
// alpzt_line_parser
// Line assembly, zone number scan and line classification. Produces up to
// two results and one zone table update per processed item.
// ----------------------------------------------------------------------------
module alpzt_line_parser #(
  parameter int ZONES    = alpzt_pkg::ZONES_DEF,
  parameter int LINE_MAX = alpzt_pkg::LINE_MAX_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         go,
  input  alpzt_pkg::in_item_t          item,
  input  logic                         cfg_we,
  input  logic [ZONES-1:0]             cfg_data,
  input  alpzt_pkg::zstate_t           rd_state,
  output logic [alpzt_pkg::ZIDX_W-1:0] rd_idx,
  output alpzt_pkg::zt_wr_t            wr,
  output logic [1:0]                   n_res,
  output alpzt_pkg::res_t              res0,
  output alpzt_pkg::res_t              res1
);
  import alpzt_pkg::*;

  localparam int LW  = $clog2(LINE_MAX + 1);
  localparam int ZIW = (ZONES > 1) ? $clog2(ZONES) : 1;

  logic [LW-1:0]    len_r, len_nxt;
  line_t            line_r, line_nxt;
  logic             dead_r, dead_nxt;
  logic [ZONES-1:0] mask_r;

  logic [5:0]       acc_m1;
  logic [ZIW-1:0]   mask_idx;

  // The table read uses the stored line; a finish on a dropped line is short
  assign acc_m1   = line_r.acc - 6'd1;
  assign rd_idx   = acc_m1[ZIDX_W-1:0];
  assign mask_idx = acc_m1[ZIW-1:0];

  always_comb begin
    line_t      lt;
    logic [LW-1:0] ln;
    logic [7:0] c;
    logic       digit;
    logic       space;
    logic [9:0] acc10;
    res_t       fin;
    zstate_t    ns;
    logic       fin_we;

    lt       = line_r;
    ln       = len_r;
    c        = item.data_byte;
    digit    = (c >= CH_0) && (c <= CH_9);
    space    = (c == CH_SP) || ((c >= CH_TAB) && (c <= CH_CR));
    acc10    = 10'(line_r.acc) * 10'd10 + 10'(c[3:0]);
    fin      = '0;
    ns       = ZS_UNKNOWN;
    fin_we   = 1'b0;
    len_nxt  = len_r;
    line_nxt = line_r;
    dead_nxt = dead_r;
    n_res    = 2'd0;
    res0     = '0;
    res1     = '0;
    wr       = '0;

    if (go) begin
      if (item.op == OP_RECONNECT) begin
        len_nxt      = '0;
        line_nxt     = LINE_CLR;
        dead_nxt     = 1'b0;
        wr.clear     = 1'b1;
        res0.status  = ST_CLEARED;
        res0.last    = 1'b1;
        n_res        = 2'd1;
      end else begin
        // Drop the partial line at a chunk start
        if (item.chunk_start) begin
          lt = LINE_CLR;
          ln = '0;
        end
        len_nxt  = ln;
        line_nxt = lt;
        dead_nxt = dead_r & ~item.chunk_start;
        if (!dead_nxt) begin
          if (c == CH_NUL) begin
            dead_nxt = 1'b1;
          end else begin
            // Restart a full line before taking the byte
            if (ln >= LW'(LINE_MAX)) begin
              lt          = LINE_CLR;
              ln          = '0;
              res0.status = ST_OVERFLOW;
              n_res       = 2'd1;
            end
            if (c == CH_NL) begin
              if (ln < LW'(2)) begin
                fin.status = ST_SHORT;
              end else if (lt.delim_c != CH_COLON) begin
                fin.status = ST_BAD_DELIM;
              end else if (lt.type_c == CH_P) begin
                fin.status = ST_PING;
              end else if (lt.type_c != CH_S) begin
                fin.status = ST_BAD_TYPE;
              end else if (!lt.seen_eq) begin
                fin.status = ST_NO_EQUALS;
              end else if ((lt.acc < 6'd1) || (lt.acc > 6'(ZONES))) begin
                fin.status = ST_BAD_ZONE;
              end else if ((lt.state_c != CH_0) && (lt.state_c != CH_1)) begin
                fin.status = ST_BAD_STATE;
              end else begin
                ns         = (lt.state_c == CH_0) ? ZS_SAFE : ZS_UNSAFE;
                fin.zone   = lt.acc[4:0];
                fin.old_s  = rd_state;
                fin.new_s  = ns;
                if (rd_state == ns) begin
                  fin.status = ST_UNCHANGED;
                end else begin
                  fin.status = ST_CHANGED;
                  fin.notify = mask_r[mask_idx];
                  fin_we     = 1'b1;
                end
              end
              fin.last = 1'b1;
              if (n_res == 2'd1) begin
                res1  = fin;
                n_res = 2'd2;
              end else begin
                res0  = fin;
                n_res = 2'd1;
              end
              wr.we    = fin_we;
              wr.idx   = rd_idx;
              wr.val   = ns;
              len_nxt  = '0;
              line_nxt = LINE_CLR;
            end else begin
              res0.last = 1'b1;
              if (ln == LW'(0)) begin
                lt.type_c = c;
              end else if (ln == LW'(1)) begin
                lt.delim_c = c;
              end else if (!lt.seen_eq) begin
                if (c == CH_EQ) begin
                  lt.seen_eq = 1'b1;
                end else begin
                  case (lt.phase)
                    PH_SKIP: begin
                      if (!space) begin
                        if (c == CH_PLUS) begin
                          lt.acc   = 6'd0;
                          lt.phase = PH_SIGN;
                        end else if (c == CH_MINUS) begin
                          lt.acc   = ACC_SAT;
                          lt.phase = PH_SIGN;
                        end else if (digit) begin
                          lt.acc   = {2'b00, c[3:0]};
                          lt.phase = PH_DIGIT;
                        end else begin
                          lt.phase = PH_DONE;
                        end
                      end
                    end
                    PH_SIGN, PH_DIGIT: begin
                      if (digit) begin
                        lt.acc   = (acc10 > 10'(ACC_SAT)) ? ACC_SAT : acc10[5:0];
                        lt.phase = PH_DIGIT;
                      end else begin
                        lt.phase = PH_DONE;
                      end
                    end
                    default: begin
                      lt.phase = PH_DONE;
                    end
                  endcase
                end
              end else if (lt.state_c == CH_NUL) begin
                lt.state_c = c;
              end
              len_nxt  = ln + LW'(1);
              line_nxt = lt;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      line_r <= LINE_CLR;
      dead_r <= 1'b0;
      mask_r <= '0;
    end else begin
      len_r  <= len_nxt;
      line_r <= line_nxt;
      dead_r <= dead_nxt;
      if (cfg_we) begin
        mask_r <= cfg_data;
      end
    end
  end

endmodule

// ===== sv/alpzt_result_fifo.sv =====
// ----------------------------------------------------------------------------
// alpzt_result_fifo
// Small result queue taking up to two entries per cycle and giving one.
// ----------------------------------------------------------------------------
module alpzt_result_fifo #(
  parameter int W = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic [1:0]   n_push,
  input  logic [W-1:0] d0,
  input  logic [W-1:0] d1,
  input  logic         pop,
  output logic         valid,
  output logic [W-1:0] q,
  output logic         room
);
  import alpzt_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  logic [W-1:0]  mem [FIFO_DEPTH];
  logic [PW-1:0] wr_r, rd_r;
  logic [CW-1:0] cnt_r;

  assign valid = (cnt_r != '0);
  assign room  = (cnt_r <= CW'(FIFO_DEPTH - 2));
  assign q     = mem[rd_r];

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem[wr_r] <= d0;
    end
    if (n_push == 2'd2) begin
      mem[wr_r + PW'(1)] <= d1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + PW'(n_push);
      rd_r  <= rd_r + PW'(pop);
      cnt_r <= cnt_r + CW'(n_push) - CW'(pop);
    end
  end

endmodule

// ===== sv/alert_line_parser_zone_table.sv =====
// ----------------------------------------------------------------------------
// alert_line_parser_zone_table
// Splits received text bytes into lines, classifies ping and zone state
// lines, keeps the per-zone state table and reports changes.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------
//  in_     | in        | in_valid / in_stall | op, data_byte, chunk_start
//  out_    | out       | out_valid/out_stall | status, zone, old/new_state,
//          |           |                     | notify, all_zone_states, last
//  cfg_    | in        | cfg_valid/cfg_ready | observer mask write data
//
//  One request per cycle sustained: a request is held in the input register,
//  is parsed and classified there, and its results are written into a
//  four-entry result queue that feeds the out_ channel.
//  A request that gives two results (overflow followed by a newline) sends
//  both through the queue's output port; the queue absorbs the extra result,
//  so the input stalls only while fewer than two slots are free (results
//  backed up by out_stall, or two-result requests close together).
//  Reset is synchronous active low: all zones unknown, line empty, queue
//  empty, observer mask zero. cfg_ready is always high.
//  in_stall rises when the held request finds fewer than two free queue slots.
// ----------------------------------------------------------------------------
module alert_line_parser_zone_table #(
  parameter int ZONES    = alpzt_pkg::ZONES_DEF,
  parameter int LINE_MAX = alpzt_pkg::LINE_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input requests
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_op,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_chunk_start,
  // results
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [3:0]           out_status,
  output logic [4:0]           out_zone,
  output logic [1:0]           out_old_state,
  output logic [1:0]           out_new_state,
  output logic                 out_notify,
  output logic [2*ZONES-1:0]   out_all_zone_states,
  output logic                 out_last,
  // observer mask write
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [ZONES-1:0]     cfg_data
);
  import alpzt_pkg::*;

  localparam int SW = 2 * ZONES;
  localparam int RW = $bits(res_t);
  localparam int FW = SW + RW;

  // Input register
  logic     in_vld_r;
  in_item_t in_item_r;

  logic     go;
  logic     room;
  logic     in_take;

  // Parser and table links
  zt_wr_t              zt_wr;
  zstate_t             rd_state;
  logic [ZIDX_W-1:0]   rd_idx;
  logic [SW-1:0]       states_nxt;
  logic [1:0]          n_res;
  res_t                res0, res1;

  // Queue
  logic [FW-1:0] q_data;
  logic          q_pop;
  res_t          q_res;

  // Process the held request only when the queue can take two results
  assign go       = in_vld_r & room;
  assign in_stall = in_vld_r & ~room;
  assign in_take  = in_valid & ~in_stall;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (go) begin
      in_vld_r <= 1'b0;
    end
  end

  // Payload holds until the next request is taken
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= '{op: in_op, data_byte: in_data_byte, chunk_start: in_chunk_start};
    end
  end

  alpzt_line_parser #(
    .ZONES    (ZONES),
    .LINE_MAX (LINE_MAX)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (go),
    .item     (in_item_r),
    .cfg_we   (cfg_valid & cfg_ready),
    .cfg_data (cfg_data),
    .rd_state (rd_state),
    .rd_idx   (rd_idx),
    .wr       (zt_wr),
    .n_res    (n_res),
    .res0     (res0),
    .res1     (res1)
  );

  alpzt_zone_table #(
    .ZONES (ZONES)
  ) u_zone_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr         (zt_wr),
    .rd_idx     (rd_idx),
    .rd_state   (rd_state),
    .states_nxt (states_nxt)
  );

  // Both results of one request carry the table as it stands after it
  alpzt_result_fifo #(
    .W (FW)
  ) u_result_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .n_push (n_res),
    .d0     ({states_nxt, res0}),
    .d1     ({states_nxt, res1}),
    .pop    (q_pop),
    .valid  (out_valid),
    .q      (q_data),
    .room   (room)
  );

  assign q_pop = out_valid & ~out_stall;
  assign q_res = res_t'(q_data[RW-1:0]);

  assign out_status          = q_res.status;
  assign out_zone            = q_res.zone;
  assign out_old_state       = q_res.old_s;
  assign out_new_state       = q_res.new_s;
  assign out_notify          = q_res.notify;
  assign out_last            = q_res.last;
  assign out_all_zone_states = q_data[FW-1:RW];

endmodule

// ===== sv/alpzt_checker.sv =====
// ----------------------------------------------------------------------------
// alpzt_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module alpzt_port_props #(
  parameter int ZONES = alpzt_pkg::ZONES_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [3:0]         out_status,
  input logic [4:0]         out_zone,
  input logic [1:0]         out_old_state,
  input logic [1:0]         out_new_state,
  input logic               out_notify,
  input logic [2*ZONES-1:0] out_all_zone_states
);
  import alpzt_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A cleared result shows an all-unknown table
  a_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_CLEARED) |->
      (out_all_zone_states == '0) && (out_zone == 5'd0))
    else $error("cleared result with nonzero zone states");

  // Notify only on a real change
  a_notify: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_notify |->
      (out_status == ST_CHANGED) && (out_old_state != out_new_state))
    else $error("notify without state change");

  // An unchanged result names a zone and matching states
  a_unchanged: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_UNCHANGED) |->
      (out_zone != 5'd0) && (out_old_state == out_new_state)
      && (out_new_state != ZS_UNKNOWN))
    else $error("unchanged result with inconsistent fields");

endmodule

bind alert_line_parser_zone_table alpzt_port_props #(
  .ZONES (ZONES)
) u_alpzt_port_props (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_status          (out_status),
  .out_zone            (out_zone),
  .out_old_state       (out_old_state),
  .out_new_state       (out_new_state),
  .out_notify          (out_notify),
  .out_all_zone_states (out_all_zone_states)
);
